[hw/rtl/edf_rm_task_picker_defines.svh]
// Assertion macros shared by the checker of the task picker.
// No dependencies; included by the files that assert.
`ifndef EDF_RM_TASK_PICKER_DEFINES_SVH
`define EDF_RM_TASK_PICKER_DEFINES_SVH

// Same-cycle implication, sampled on clock, quiet while reset is high.
`define ERP_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, quiet while reset is high.
`define ERP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/erp_pkg.sv]
// Shared types, codes and constant functions of the task picker.
// No dependencies; imported by every module of the block but erp_div.
`timescale 1ns / 1ps

package erp_pkg;

   localparam int CMD_W      = 3;
   localparam int PID_W      = 16;
   localparam int VAL_W      = 31;
   localparam int TICK_W     = 32;
   localparam int STAT_W     = 3;
   localparam int OUT_SLOT_W = 6;
   localparam int POL_W      = 2;
   localparam int WGT_W      = 3;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 24;

   localparam int SLOTS_DEF     = 64;
   localparam int FRAC_BITS_DEF = 16;

   localparam logic [CMD_W-1:0] CMD_PICK       = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ADD        = 3'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SET_EXEC   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_SET_DL     = 3'd4;
   localparam logic [CMD_W-1:0] CMD_SET_RATE   = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SET_POLICY = 3'd6;
   localparam logic [CMD_W-1:0] CMD_READY      = 3'd7;

   localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND  = 3'd1;
   localparam logic [STAT_W-1:0] ST_POL_SET    = 3'd2;
   localparam logic [STAT_W-1:0] ST_REJECT     = 3'd3;
   localparam logic [STAT_W-1:0] ST_NONE_READY = 3'd4;

   localparam logic [POL_W-1:0] POL_EDF  = 2'd0;
   localparam logic [POL_W-1:0] POL_RM   = 2'd1;
   localparam logic [POL_W-1:0] POL_NONE = 2'd2;

   localparam logic [63:0] ONE_Q24 = 64'd1 << 24;

   // One table entry.
   typedef struct packed {
      logic [PID_W-1:0]  pid;
      logic [POL_W-1:0]  policy;
      logic [VAL_W-1:0]  deadline;
      logic [TICK_W-1:0] arrival;
      logic [VAL_W-1:0]  run_time;
      logic [VAL_W-1:0]  rate;
      logic [WGT_W-1:0]  weight;
   } ent_type;

   // Controller commands to the datapath.
   typedef struct packed {
      logic load;
      logic rd_en;
      logic scan_a;
      logic exec;
      logic eval_b;
      logic fin;
   } ctl_type;

   // Datapath status to the controller.
   typedef struct packed {
      logic need_adm;
      logic div_idle;
   } sts_type;

   // max(1, trunc(((30-rate)*3+28)/29)); only rates below 30 give more than 1.
   function automatic logic [WGT_W-1:0] weight_of(input logic [VAL_W-1:0] rate);
      logic [6:0] num;
      logic [WGT_W-1:0] w;
      num = 7'd118 - 7'(3 * rate[4:0]);
      if (num >= 7'd116) begin
         w = 3'd4;
      end else if (num >= 7'd87) begin
         w = 3'd3;
      end else if (num >= 7'd58) begin
         w = 3'd2;
      end else begin
         w = 3'd1;
      end
      if (rate > 31'd29) begin
         w = 3'd1;
      end
      return w;
   endfunction

   // True when x (Q24) raised to n stays at or below 2.0.
   function automatic logic pow_fits(input logic [63:0] x, input int n);
      logic [63:0] acc;
      logic over;
      acc = ONE_Q24;
      over = 1'b0;
      for (int i = 0; i < n; i++) begin
         if (!over) begin
            acc = (acc * x) >> 24;
            if (acc > 2 * ONE_Q24) begin
               over = 1'b1;
            end
         end
      end
      return !over;
   endfunction

   // Liu-Layland bound times n in Q24: n*(2^(1/n)-1). Elaboration only.
   function automatic logic [63:0] bound_q24(input int n);
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      lo = ONE_Q24;
      hi = 2 * ONE_Q24 + 1;
      if (n == 0) begin
         return 64'd0;
      end
      for (int i = 0; i < 32; i++) begin
         if (hi - lo > 1) begin
            mid = lo + ((hi - lo) >> 1);
            if (pow_fits(mid, n)) begin
               lo = mid;
            end else begin
               hi = mid;
            end
         end
      end
      return 64'(n) * (lo - ONE_Q24);
   endfunction

endpackage

[hw/rtl/erp_ctrl.sv]
// Sequencer of the task picker: scan, execute, admission scan, respond.
// Depends on erp_pkg.
`timescale 1ns / 1ps

module erp_ctrl #(
   parameter int SLOTS = erp_pkg::SLOTS_DEF,
   localparam int SLOT_W = $clog2(SLOTS)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             out_free,
   output logic             rsp_load,
   input  erp_pkg::sts_type sts,
   output erp_pkg::ctl_type ctl,
   output logic [SLOT_W-1:0] rd_addr
);
   import erp_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_A_RD   = 4'd1;
   localparam logic [3:0] S_A_END  = 4'd2;
   localparam logic [3:0] S_EXEC   = 4'd3;
   localparam logic [3:0] S_B_RD   = 4'd4;
   localparam logic [3:0] S_B_EVAL = 4'd5;
   localparam logic [3:0] S_B_WAIT = 4'd6;
   localparam logic [3:0] S_B_FIN  = 4'd7;
   localparam logic [3:0] S_DONE   = 4'd8;

   localparam logic [SLOT_W-1:0] LAST = SLOT_W'(SLOTS - 1);

   logic [3:0]        state_ff, state_in;
   logic [SLOT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      ctl       = '0;
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      rd_addr   = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.load = 1'b1;
               cnt_in   = '0;
               state_in = S_A_RD;
            end
         end
         S_A_RD: begin
            ctl.rd_en  = 1'b1;
            ctl.scan_a = 1'b1;
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == LAST) begin
               state_in = S_A_END;
            end
         end
         S_A_END: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            ctl.exec = 1'b1;
            cnt_in   = '0;
            state_in = sts.need_adm ? S_B_RD : S_DONE;
         end
         S_B_RD: begin
            ctl.rd_en = 1'b1;
            state_in  = S_B_EVAL;
         end
         S_B_EVAL: begin
            ctl.eval_b = 1'b1;
            state_in   = S_B_WAIT;
         end
         S_B_WAIT: begin
            if (sts.div_idle) begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = (cnt_ff == LAST) ? S_B_FIN : S_B_RD;
            end
         end
         S_B_FIN: begin
            ctl.fin  = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

[hw/rtl/erp_div.sv]
// Restoring bit-serial divider, one quotient bit per cycle.
// Depends on nothing outside this file.
`timescale 1ns / 1ps

module erp_div #(
   parameter int DVD_W = 47,
   parameter int DVS_W = 31
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             busy,
   output logic             done,
   output logic [DVD_W-1:0] quot
);
   localparam int CNT_W = $clog2(DVD_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W:0]   rem_sh;
   logic [DVS_W:0]   diff;
   logic             fits;

   assign rem_sh = {rem_ff, quo_ff[DVD_W-1]};
   assign diff   = rem_sh - {1'b0, dvs_ff};
   assign fits   = rem_sh >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = quo_ff;

endmodule

[hw/rtl/erp_dpath.sv]
// Task table, scan accumulators, admission sums and result registers.
// Depends on erp_pkg and erp_div.
`timescale 1ns / 1ps

module erp_dpath #(
   parameter int SLOTS     = erp_pkg::SLOTS_DEF,
   parameter int FRAC_BITS = erp_pkg::FRAC_BITS_DEF,
   localparam int SLOT_W   = $clog2(SLOTS)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  erp_pkg::ctl_type             ctl,
   input  logic [SLOT_W-1:0]            rd_addr,
   input  logic [erp_pkg::CMD_W-1:0]    req_cmd,
   input  logic [erp_pkg::PID_W-1:0]    req_pid,
   input  logic [erp_pkg::VAL_W-1:0]    req_val,
   input  logic [erp_pkg::TICK_W-1:0]   req_now,
   output erp_pkg::sts_type             sts,
   output logic [erp_pkg::STAT_W-1:0]   res_status,
   output logic [erp_pkg::PID_W-1:0]    res_pid,
   output logic [SLOT_W-1:0]            res_slot
);
   import erp_pkg::*;

   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int DVD_W = VAL_W + FRAC_BITS;
   localparam int SUM_W = (DVD_W > 2 * VAL_W) ? DVD_W + 7 : 2 * VAL_W + 7;
   localparam int KEY_W = TICK_W + 1;
   localparam logic [SLOT_W-1:0] LAST = SLOT_W'(SLOTS - 1);

   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] fslot;
      ent_type           fent;
      logic              free_have;
      logic [SLOT_W-1:0] free_slot;
      logic              polf;
      logic [POL_W-1:0]  pol;
      logic              edf_have;
      logic [KEY_W-1:0]  edf_key;
      logic [PID_W-1:0]  edf_pid;
      logic [SLOT_W-1:0] edf_slot;
      logic              rm_have;
      logic [WGT_W-1:0]  rm_wgt;
      logic [PID_W-1:0]  rm_pid;
      logic [SLOT_W-1:0] rm_slot;
      logic              any_have;
      logic [PID_W-1:0]  any_pid;
      logic [SLOT_W-1:0] any_slot;
      logic              ge_have;
      logic [PID_W-1:0]  ge_pid;
      logic [SLOT_W-1:0] ge_slot;
   } scan_type;

   // Table storage: one entry per slot, one write and one read per cycle.
   ent_type slot_mem [SLOTS];
   ent_type rd_ent_ff;

   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   logic [PID_W-1:0]   pid_ff, pid_in;
   logic [VAL_W-1:0]   val_ff, val_in;
   logic [TICK_W-1:0]  now_ff, now_in;
   scan_type           scan_ff, scan_in;
   logic [SLOTS-1:0]   used_ff, used_in;
   logic [SLOTS-1:0]   ready_ff, ready_in;
   logic [SLOT_W-1:0]  robin_ff, robin_in;
   logic               rd_a_ff, rd_a_in;
   logic [SLOT_W-1:0]  rd_idx_ff, rd_idx_in;
   logic               used_rd_ff, used_rd_in;
   logic               ready_rd_ff, ready_rd_in;
   logic [POL_W-1:0]   adm_pol_ff, adm_pol_in;
   ent_type            wr_ent_ff, wr_ent_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [CNT_W-1:0]   num_ff, num_in;
   logic               rej0_ff, rej0_in;
   logic [2*VAL_W-1:0] prod_ff, prod_in;
   logic               prod_vld_ff, prod_vld_in;
   logic [STAT_W-1:0]  res_status_ff, res_status_in;
   logic [PID_W-1:0]   res_pid_ff, res_pid_in;
   logic [SLOT_W-1:0]  res_slot_ff, res_slot_in;

   logic              mem_we;
   logic [SLOT_W-1:0] mem_wa;
   ent_type           mem_wd;
   ent_type           new_ent;
   logic              div_start;
   logic              div_busy;
   logic              div_done;
   logic [DVD_W-1:0]  div_quot;
   logic [KEY_W-1:0]  a_key;
   logic              a_ur;
   logic [POL_W-1:0]  pol_req;
   logic [POL_W-1:0]  pick_pol;
   logic [SLOT_W-1:0] pick_slot;
   logic [PID_W-1:0]  pick_pid;
   logic              reject;
   logic [63:0]       lim_tab [SLOTS+1];

   // RM limit per task count: (100 * bound) in whole percent units.
   for (genvar gn = 0; gn <= SLOTS; gn++) begin : g_lim
      localparam logic [63:0] LQ = bound_q24(gn);
      assign lim_tab[gn] = 64'((64'd100 * (LQ >> (24 - FRAC_BITS))) >> FRAC_BITS);
   end

   erp_div #(
      .DVD_W(DVD_W),
      .DVS_W(VAL_W)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend({rd_ent_ff.run_time, FRAC_BITS'(0)}),
      .divisor (rd_ent_ff.deadline),
      .busy    (div_busy),
      .done    (div_done),
      .quot    (div_quot)
   );

   assign a_key   = {1'b0, TICK_W'(rd_ent_ff.deadline)} + {1'b0, rd_ent_ff.arrival};
   assign a_ur    = used_rd_ff && ready_rd_ff;
   assign pol_req = (val_ff > VAL_W'(POL_NONE)) ? POL_NONE : val_ff[POL_W-1:0];
   assign pick_pol = scan_ff.polf ? scan_ff.pol : POL_NONE;

   always_comb begin
      case (pick_pol)
         POL_EDF: begin
            pick_slot = scan_ff.edf_slot;
            pick_pid  = scan_ff.edf_pid;
         end
         POL_RM: begin
            pick_slot = scan_ff.rm_slot;
            pick_pid  = scan_ff.rm_pid;
         end
         default: begin
            pick_slot = scan_ff.ge_have ? scan_ff.ge_slot : scan_ff.any_slot;
            pick_pid  = scan_ff.ge_have ? scan_ff.ge_pid : scan_ff.any_pid;
         end
      endcase
   end

   assign reject = (adm_pol_ff == POL_EDF)
      ? (rej0_ff || (sum_ff > (SUM_W'(1) << FRAC_BITS)))
      : ((num_ff != '0) && (sum_ff > SUM_W'(lim_tab[num_ff])));

   assign sts.need_adm = (cmd_ff == CMD_SET_POLICY) && scan_ff.found && (pol_req != POL_NONE);
   assign sts.div_idle = !div_busy && !div_done;

   always_comb begin
      cmd_in        = cmd_ff;
      pid_in        = pid_ff;
      val_in        = val_ff;
      now_in        = now_ff;
      scan_in       = scan_ff;
      used_in       = used_ff;
      ready_in      = ready_ff;
      robin_in      = robin_ff;
      rd_a_in       = ctl.rd_en && ctl.scan_a;
      rd_idx_in     = rd_addr;
      used_rd_in    = used_ff[rd_addr];
      ready_rd_in   = ready_ff[rd_addr];
      adm_pol_in    = adm_pol_ff;
      wr_ent_in     = wr_ent_ff;
      sum_in        = sum_ff;
      num_in        = num_ff;
      rej0_in       = rej0_ff;
      prod_in       = prod_ff;
      prod_vld_in   = 1'b0;
      res_status_in = res_status_ff;
      res_pid_in    = res_pid_ff;
      res_slot_in   = res_slot_ff;
      mem_we        = 1'b0;
      mem_wa        = scan_ff.fslot;
      mem_wd        = scan_ff.fent;
      new_ent       = scan_ff.fent;
      div_start     = 1'b0;

      if (ctl.load) begin
         cmd_in  = req_cmd;
         pid_in  = req_pid;
         val_in  = req_val;
         now_in  = req_now;
         scan_in = '0;
      end

      // Table scan: lookup, free slot, pick candidates for every policy.
      if (rd_a_ff) begin
         if (used_rd_ff && rd_ent_ff.pid == pid_ff && !scan_ff.found) begin
            scan_in.found = 1'b1;
            scan_in.fslot = rd_idx_ff;
            scan_in.fent  = rd_ent_ff;
         end
         if (!used_rd_ff && !scan_ff.free_have) begin
            scan_in.free_have = 1'b1;
            scan_in.free_slot = rd_idx_ff;
         end
         if (a_ur && rd_ent_ff.policy != POL_NONE && !scan_ff.polf) begin
            scan_in.polf = 1'b1;
            scan_in.pol  = rd_ent_ff.policy;
         end
         if (a_ur && (!scan_ff.edf_have || a_key < scan_ff.edf_key ||
             (a_key == scan_ff.edf_key && rd_ent_ff.pid < scan_ff.edf_pid))) begin
            scan_in.edf_have = 1'b1;
            scan_in.edf_key  = a_key;
            scan_in.edf_pid  = rd_ent_ff.pid;
            scan_in.edf_slot = rd_idx_ff;
         end
         if (a_ur && (!scan_ff.rm_have || rd_ent_ff.weight < scan_ff.rm_wgt ||
             (rd_ent_ff.weight == scan_ff.rm_wgt && rd_ent_ff.pid < scan_ff.rm_pid))) begin
            scan_in.rm_have = 1'b1;
            scan_in.rm_wgt  = rd_ent_ff.weight;
            scan_in.rm_pid  = rd_ent_ff.pid;
            scan_in.rm_slot = rd_idx_ff;
         end
         if (a_ur && !scan_ff.any_have) begin
            scan_in.any_have = 1'b1;
            scan_in.any_pid  = rd_ent_ff.pid;
            scan_in.any_slot = rd_idx_ff;
         end
         if (a_ur && rd_idx_ff >= robin_ff && !scan_ff.ge_have) begin
            scan_in.ge_have = 1'b1;
            scan_in.ge_pid  = rd_ent_ff.pid;
            scan_in.ge_slot = rd_idx_ff;
         end
      end

      if (ctl.exec) begin
         res_status_in = ST_OK;
         res_pid_in    = '0;
         res_slot_in   = '0;
         case (cmd_ff)
            CMD_PICK: begin
               if (!scan_ff.any_have) begin
                  res_status_in = ST_NONE_READY;
               end else begin
                  ready_in[pick_slot] = 1'b0;
                  res_pid_in  = pick_pid;
                  res_slot_in = pick_slot;
                  if (pick_pol == POL_NONE) begin
                     robin_in = (pick_slot == LAST) ? '0 : pick_slot + 1'b1;
                  end
               end
            end
            CMD_ADD: begin
               if (scan_ff.found || !scan_ff.free_have) begin
                  res_status_in = ST_NOT_FOUND;
               end else begin
                  new_ent        = '0;
                  new_ent.pid    = pid_ff;
                  new_ent.policy = POL_NONE;
                  mem_we         = 1'b1;
                  mem_wa         = scan_ff.free_slot;
                  used_in[scan_ff.free_slot]  = 1'b1;
                  ready_in[scan_ff.free_slot] = 1'b0;
                  res_slot_in    = scan_ff.free_slot;
               end
            end
            default: begin
               if (!scan_ff.found) begin
                  res_status_in = ST_NOT_FOUND;
               end else begin
                  res_slot_in = scan_ff.fslot;
                  case (cmd_ff)
                     CMD_REMOVE: begin
                        used_in[scan_ff.fslot]  = 1'b0;
                        ready_in[scan_ff.fslot] = 1'b0;
                     end
                     CMD_READY: begin
                        ready_in[scan_ff.fslot] = 1'b1;
                     end
                     CMD_SET_POLICY: begin
                        new_ent.policy  = pol_req;
                        new_ent.arrival = now_ff;
                        mem_we     = 1'b1;
                        wr_ent_in  = new_ent;
                        adm_pol_in = pol_req;
                        sum_in     = '0;
                        num_in     = '0;
                        rej0_in    = 1'b0;
                     end
                     default: begin
                        case (cmd_ff)
                           CMD_SET_EXEC: new_ent.run_time = val_ff;
                           CMD_SET_DL:   new_ent.deadline = val_ff;
                           default: begin
                              new_ent.rate   = val_ff;
                              new_ent.weight = weight_of(val_ff);
                           end
                        endcase
                        mem_we = 1'b1;
                        if (scan_ff.fent.policy != POL_NONE) begin
                           res_status_in = ST_POL_SET;
                        end
                     end
                  endcase
               end
            end
         endcase
         mem_wd = new_ent;
      end

      // Admission scan: one slot per visit; EDF slots with a nonzero deadline go through the divider.
      if (ctl.eval_b && used_rd_ff && rd_ent_ff.policy == adm_pol_ff) begin
         num_in = num_ff + CNT_W'(1);
         if (adm_pol_ff == POL_EDF) begin
            if (rd_ent_ff.deadline == '0) begin
               rej0_in = 1'b1;
            end else begin
               div_start = 1'b1;
            end
         end else begin
            prod_in     = rd_ent_ff.run_time * rd_ent_ff.rate;
            prod_vld_in = 1'b1;
         end
      end

      if (prod_vld_ff) begin
         sum_in = sum_ff + SUM_W'(prod_ff);
      end else if (div_done) begin
         sum_in = sum_ff + SUM_W'(div_quot);
      end

      if (ctl.fin && reject) begin
         mem_we         = 1'b1;
         mem_wd         = wr_ent_ff;
         mem_wd.policy  = POL_NONE;
         res_status_in  = ST_REJECT;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_wa] <= mem_wd;
      end
      if (ctl.rd_en) begin
         rd_ent_ff <= slot_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff     <= '0;
         ready_ff    <= '0;
         robin_ff    <= '0;
         rd_a_ff     <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         used_ff     <= used_in;
         ready_ff    <= ready_in;
         robin_ff    <= robin_in;
         rd_a_ff     <= rd_a_in;
         prod_vld_ff <= prod_vld_in;
      end
      cmd_ff        <= cmd_in;
      pid_ff        <= pid_in;
      val_ff        <= val_in;
      now_ff        <= now_in;
      scan_ff       <= scan_in;
      rd_idx_ff     <= rd_idx_in;
      used_rd_ff    <= used_rd_in;
      ready_rd_ff   <= ready_rd_in;
      adm_pol_ff    <= adm_pol_in;
      wr_ent_ff     <= wr_ent_in;
      sum_ff        <= sum_in;
      num_ff        <= num_in;
      rej0_ff       <= rej0_in;
      prod_ff       <= prod_in;
      res_status_ff <= res_status_in;
      res_pid_ff    <= res_pid_in;
      res_slot_ff   <= res_slot_in;
   end

   assign res_status = res_status_ff;
   assign res_pid    = res_pid_ff;
   assign res_slot   = res_slot_ff;

endmodule

[hw/rtl/edf_rm_task_picker.sv]
// Each command makes one table scan; an EDF/RM set policy adds an admission scan
//   over every slot, and each EDF slot with a nonzero deadline goes through the
//   bit-serial divider. One transaction is in flight at a time; a waiting
//   response sits in the output register.
// Reset (synchronous, active high) clears used/ready bits and the round-robin pointer.
`timescale 1ns / 1ps

module edf_rm_task_picker #(
   parameter int SLOTS     = erp_pkg::SLOTS_DEF,
   parameter int FRAC_BITS = erp_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // {pad[79], now_ticks[78:47], operand_value[46:16], task_pid[15:0]}
   input  logic [erp_pkg::REQ_DATA_W-1:0]    req_tdata,
   // command[2:0]
   input  logic [erp_pkg::CMD_W-1:0]         req_tuser,
   // Response channel.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // {pad[23:22], chosen_slot[21:16], chosen_pid[15:0]}
   output logic [erp_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // status[2:0]
   output logic [erp_pkg::STAT_W-1:0]        rsp_tuser
);
   import erp_pkg::*;

   localparam int SLOT_W = $clog2(SLOTS);

   ctl_type           ctl;
   sts_type           sts;
   logic [SLOT_W-1:0] rd_addr;
   logic              rsp_load;
   logic              out_free;
   logic [STAT_W-1:0] res_status;
   logic [PID_W-1:0]  res_pid;
   logic [SLOT_W-1:0] res_slot;

   // Output register: holds a finished response while the consumer stalls.
   logic                  rsp_vld_ff, rsp_vld_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [STAT_W-1:0]     rsp_user_ff, rsp_user_in;

   assign out_free = !rsp_vld_ff || rsp_tready;

   erp_ctrl #(
      .SLOTS(SLOTS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_tvalid),
      .req_ready(req_tready),
      .out_free (out_free),
      .rsp_load (rsp_load),
      .sts      (sts),
      .ctl      (ctl),
      .rd_addr  (rd_addr)
   );

   erp_dpath #(
      .SLOTS    (SLOTS),
      .FRAC_BITS(FRAC_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .rd_addr   (rd_addr),
      .req_cmd   (req_tuser),
      .req_pid   (req_tdata[15:0]),
      .req_val   (req_tdata[46:16]),
      .req_now   (req_tdata[78:47]),
      .sts       (sts),
      .res_status(res_status),
      .res_pid   (res_pid),
      .res_slot  (res_slot)
   );

   always_comb begin
      rsp_vld_in  = rsp_vld_ff;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      if (rsp_vld_ff && rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_vld_in  = 1'b1;
         rsp_data_in = {2'b00, OUT_SLOT_W'(res_slot), res_pid};
         rsp_user_in = res_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

[hw/rtl/erp_chk.sv]
// Port-level checker of the task picker, bound to the top level.
// Depends on erp_pkg and edf_rm_task_picker_defines.svh.
`timescale 1ns / 1ps
`include "edf_rm_task_picker_defines.svh"

module erp_chk (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [erp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [erp_pkg::STAT_W-1:0]     rsp_tuser
);
   import erp_pkg::*;

   // A stalled response keeps its payload.
   `ERP_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "response changed while stalled")

   // Status is one of the defined codes.
   `ERP_ASSERT_NOW(a_status_code, rsp_tvalid, rsp_tuser == ST_OK || rsp_tuser == ST_NOT_FOUND || rsp_tuser == ST_POL_SET || rsp_tuser == ST_REJECT || rsp_tuser == ST_NONE_READY, "undefined status")

   // A miss or an empty pick reports no pid and slot zero.
   `ERP_ASSERT_NOW(a_miss_zero, rsp_tvalid && (rsp_tuser == ST_NOT_FOUND || rsp_tuser == ST_NONE_READY), rsp_tdata == '0, "nonzero payload on miss")

   // One transaction in flight: a request is never taken twice in a row.
   `ERP_ASSERT_NEXT(a_one_in_flight, req_tvalid && req_tready, !req_tready, "request taken while busy")

endmodule

bind edf_rm_task_picker erp_chk u_chk (.*);

[sim/edf_rm_task_picker_checker.sv]
// Scoreboard for the task picker: watches both channels and predicts each response.
// It keeps its own copy of the task table. Depends on erp_pkg for the codes and widths.
`timescale 1ns / 1ps

module edf_rm_task_picker_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [erp_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [erp_pkg::CMD_W-1:0]      req_tuser,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [erp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic [erp_pkg::STAT_W-1:0]     rsp_tuser,
   output int                             mismatch_count,
   output int                             pending_count
);
   import erp_pkg::*;

   localparam int NSLOT = 64;
   localparam int FRAC  = 16;
   localparam longint unsigned Q24_ONE = 64'd1 << 24;

   typedef struct packed {
      logic [STAT_W-1:0]     status;
      logic [PID_W-1:0]      pid;
      logic [OUT_SLOT_W-1:0] slot;
   } sched_rsp_type;

   sched_rsp_type expected_rsp[$];

   bit                used_tab[NSLOT];
   bit                ready_tab[NSLOT];
   logic [PID_W-1:0]  pid_tab[NSLOT];
   logic [POL_W-1:0]  policy_tab[NSLOT];
   logic [31:0]       deadline_tab[NSLOT];
   logic [31:0]       arrival_tab[NSLOT];
   logic [31:0]       exec_tab[NSLOT];
   logic [31:0]       rate_tab[NSLOT];
   logic [31:0]       weight_tab[NSLOT];
   int                robin_next;
   longint unsigned   ll_bound[0:64];

   // Q24 power with early exit once above 2.0
   function automatic bit q24_power_fits(longint unsigned x, int n);
      longint unsigned acc;
      acc = Q24_ONE;
      for (int i = 0; i < n; i++) begin
         acc = (acc * x) >> 24;
         if (acc > 2 * Q24_ONE) return 1'b0;
      end
      return acc <= 2 * Q24_ONE;
   endfunction

   initial begin
      longint unsigned lo, hi, mid;
      ll_bound[0] = 0;
      for (int n = 1; n <= 64; n++) begin
         lo = Q24_ONE;
         hi = 2 * Q24_ONE + 1;
         while (hi - lo > 1) begin
            mid = lo + (hi - lo) / 2;
            if (q24_power_fits(mid, n)) lo = mid;
            else hi = mid;
         end
         ll_bound[n] = longint'(n) * (lo - Q24_ONE);
      end
   end

   function automatic int lookup_pid(logic [PID_W-1:0] pid);
      for (int i = 0; i < NSLOT; i++)
         if (used_tab[i] && pid_tab[i] == pid) return i;
      return -1;
   endfunction

   function automatic bit edf_admits();
      longint unsigned sum;
      sum = 0;
      for (int i = 0; i < NSLOT; i++) begin
         if (!used_tab[i] || policy_tab[i] != POL_EDF) continue;
         if (deadline_tab[i] == 0) return 1'b0;
         sum += ({32'd0, exec_tab[i]} << FRAC) / {32'd0, deadline_tab[i]};
      end
      return sum <= (64'd1 << FRAC);
   endfunction

   function automatic bit rm_admits();
      longint unsigned sum, prod, limit;
      int n;
      sum = 0;
      n = 0;
      for (int i = 0; i < NSLOT; i++) begin
         if (!used_tab[i] || policy_tab[i] != POL_RM) continue;
         n++;
         prod = {32'd0, exec_tab[i]} * {32'd0, rate_tab[i]};
         sum = (sum > 64'hFFFF_FFFF_FFFF_FFFF - prod) ? 64'hFFFF_FFFF_FFFF_FFFF : sum + prod;
      end
      if (n == 0) return 1'b1;
      limit = (100 * (ll_bound[n] >> (24 - FRAC))) >> FRAC;
      return sum <= limit;
   endfunction

   function automatic int best_ready(logic [POL_W-1:0] pol);
      int best;
      longint unsigned key, best_key;
      best = -1;
      best_key = 0;
      for (int i = 0; i < NSLOT; i++) begin
         if (!used_tab[i] || !ready_tab[i]) continue;
         key = (pol == POL_EDF) ? {32'd0, deadline_tab[i]} + {32'd0, arrival_tab[i]}
                                : {32'd0, weight_tab[i]};
         if (best < 0 || key < best_key || (key == best_key && pid_tab[i] < pid_tab[best])) begin
            best = i;
            best_key = key;
         end
      end
      return best;
   endfunction

   function automatic int robin_ready();
      int s;
      for (int k = 0; k < NSLOT; k++) begin
         s = (robin_next + k) % NSLOT;
         if (used_tab[s] && ready_tab[s]) begin
            robin_next = (s + 1) % NSLOT;
            return s;
         end
      end
      return -1;
   endfunction

   // Applies one command to the shadow table and returns the response it should give.
   function automatic sched_rsp_type schedule_command(logic [CMD_W-1:0] cmd,
                                                      logic [PID_W-1:0] pid,
                                                      logic [VAL_W-1:0] val, logic [31:0] now);
      sched_rsp_type r;
      logic [POL_W-1:0] pol;
      longint w;
      int s;
      r = '0;
      r.status = ST_OK;
      if (cmd == CMD_PICK) begin
         pol = POL_NONE;
         for (int i = 0; i < NSLOT; i++)
            if (used_tab[i] && ready_tab[i] && policy_tab[i] != POL_NONE) begin
               pol = policy_tab[i];
               break;
            end
         s = (pol == POL_NONE) ? robin_ready() : best_ready(pol);
         if (s < 0) begin
            r.status = ST_NONE_READY;
         end else begin
            ready_tab[s] = 1'b0;
            r.pid = pid_tab[s];
            r.slot = s[OUT_SLOT_W-1:0];
         end
      end else if (cmd == CMD_ADD) begin
         s = -1;
         if (lookup_pid(pid) < 0)
            for (int i = 0; i < NSLOT; i++)
               if (!used_tab[i]) begin
                  s = i;
                  break;
               end
         if (s < 0) begin
            r.status = ST_NOT_FOUND;
         end else begin
            used_tab[s] = 1'b1;
            pid_tab[s] = pid;
            ready_tab[s] = 1'b0;
            policy_tab[s] = POL_NONE;
            deadline_tab[s] = 0;
            arrival_tab[s] = 0;
            exec_tab[s] = 0;
            rate_tab[s] = 0;
            weight_tab[s] = 0;
            r.slot = s[OUT_SLOT_W-1:0];
         end
      end else begin
         s = lookup_pid(pid);
         if (s < 0) begin
            r.status = ST_NOT_FOUND;
         end else begin
            r.slot = s[OUT_SLOT_W-1:0];
            case (cmd)
               CMD_REMOVE: begin
                  used_tab[s] = 1'b0;
                  ready_tab[s] = 1'b0;
               end
               CMD_READY: ready_tab[s] = 1'b1;
               CMD_SET_POLICY: begin
                  pol = (val > POL_NONE) ? POL_NONE : val[POL_W-1:0];
                  policy_tab[s] = pol;
                  arrival_tab[s] = now;
                  if ((pol == POL_EDF && !edf_admits()) || (pol == POL_RM && !rm_admits())) begin
                     policy_tab[s] = POL_NONE;
                     r.status = ST_REJECT;
                  end
               end
               default: begin
                  if (cmd == CMD_SET_EXEC) begin
                     exec_tab[s] = {1'b0, val};
                  end else if (cmd == CMD_SET_DL) begin
                     deadline_tab[s] = {1'b0, val};
                  end else begin
                     w = ((64'sd30 - longint'(val)) * 3 + 28) / 29;
                     if (w < 1) w = 1;
                     rate_tab[s] = {1'b0, val};
                     weight_tab[s] = w[31:0];
                  end
                  if (policy_tab[s] != POL_NONE) r.status = ST_POL_SET;
               end
            endcase
         end
      end
      return r;
   endfunction

   assign pending_count = expected_rsp.size();

   always @(posedge clock) begin
      sched_rsp_type want;
      if (reset) begin
         for (int i = 0; i < NSLOT; i++) begin
            used_tab[i] = 1'b0;
            ready_tab[i] = 1'b0;
         end
         robin_next = 0;
         expected_rsp.delete();
         mismatch_count <= 0;
      end else begin
         if (req_tvalid && req_tready)
            expected_rsp.push_back(schedule_command(req_tuser, req_tdata[15:0],
                                                    req_tdata[46:16], req_tdata[78:47]));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsp.size() == 0) begin
               $error("unexpected response transaction: status %0d pid %0d slot %0d",
                      rsp_tuser, rsp_tdata[15:0], rsp_tdata[21:16]);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = expected_rsp.pop_front();
               if (want.status !== rsp_tuser || want.pid !== rsp_tdata[15:0] ||
                   want.slot !== rsp_tdata[21:16]) begin
                  if (want.status !== rsp_tuser)
                     $error("status: expected %0d, got %0d", want.status, rsp_tuser);
                  if (want.pid !== rsp_tdata[15:0])
                     $error("chosen_pid: expected %0d, got %0d", want.pid, rsp_tdata[15:0]);
                  if (want.slot !== rsp_tdata[21:16])
                     $error("chosen_slot: expected %0d, got %0d", want.slot, rsp_tdata[21:16]);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
      end
   end

endmodule

[sim/tb_edf_rm_task_picker.sv]
// Top of the task picker testbench: clock, reset, command stimulus and the verdict.
// Depends on erp_pkg, edf_rm_task_picker and edf_rm_task_picker_checker.
`timescale 1ns / 1ps

module tb_edf_rm_task_picker;
   import erp_pkg::*;

   // Worst command is an EDF admission over a full table; ~460 such commands
   // with stalls on both sides still finish far below this limit.
   localparam int CYCLE_LIMIT = 10_000_000;
   localparam int HOLD_CYCLES = 400;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [CMD_W-1:0]      req_tuser = CMD_PICK;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STAT_W-1:0]     rsp_tuser;

   int mismatch_count;
   int pending_count;
   int cycle_count = 0;
   int sent_count = 0;
   int rsp_count = 0;

   // Small pid pool so that commands mostly hit tasks that exist; includes the extremes.
   logic [PID_W-1:0] pid_pool[8] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h00A5,
                                     16'h5A5A, 16'h8000, 16'h1234, 16'h7FFF};

   edf_rm_task_picker uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   edf_rm_task_picker_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Response side: random stall per transaction, quiet stretches every third
   // window of 40, and one long hold-off so the block backs up onto its input.
   initial begin
      int  stall;
      bit  held;
      held = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_count == 120 && !held) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         stall = ((rsp_count / 40) % 3 == 0) ? 0 : $urandom_range(0, 5);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         rsp_count++;
      end
   end

   // One request transaction. Valid only drops when a gap is drawn, so a
   // back-to-back command never sees valid lowered and raised in one step.
   task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [PID_W-1:0] pid,
                           logic [VAL_W-1:0] val, logic [31:0] now);
      int gap;
      gap = ((sent_count / 50) % 4 == 1) ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {1'b0, now, val, pid};
      do @(posedge clock); while (!req_tready);
      sent_count++;
   endtask

   function automatic logic [PID_W-1:0] some_pid();
      return ($urandom_range(0, 9) < 8) ? pid_pool[3'($urandom_range(0, 7))]
                                        : PID_W'($urandom);
   endfunction

   // Operand shaped by command: mostly small sensible values, sometimes full range.
   function automatic logic [VAL_W-1:0] some_operand(logic [CMD_W-1:0] cmd);
      if ($urandom_range(0, 9) == 0) return VAL_W'($urandom);
      case (cmd)
         CMD_SET_EXEC:   return VAL_W'($urandom_range(0, 40));
         CMD_SET_DL:     return ($urandom_range(0, 15) == 0) ? '0
                                                             : VAL_W'($urandom_range(1, 300));
         CMD_SET_RATE:   return VAL_W'($urandom_range(0, 40));
         CMD_SET_POLICY: return VAL_W'($urandom_range(0, 3));
         default:        return VAL_W'($urandom);
      endcase
   endfunction

   initial begin
      logic [PID_W-1:0] p;
      logic [CMD_W-1:0] c;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty pick, duplicates, absent pids, weight edges,
      // zero-deadline and overload rejects, policy-already-set, odd policy codes.
      send_cmd(CMD_PICK,       16'h0000, '1, '1);
      send_cmd(CMD_ADD,        16'h0000, 31'd0, 32'd0);
      send_cmd(CMD_ADD,        16'hFFFF, '1, '1);
      send_cmd(CMD_ADD,        16'h0000, 31'd0, 32'd0);
      send_cmd(CMD_SET_EXEC,   16'h4242, 31'd5, 32'd0);
      send_cmd(CMD_READY,      16'h4242, 31'd0, 32'd0);
      send_cmd(CMD_REMOVE,     16'h4242, 31'd0, 32'd0);
      send_cmd(CMD_SET_RATE,   16'h0000, 31'd0, 32'd0);
      send_cmd(CMD_SET_RATE,   16'hFFFF, 31'd29, 32'd0);
      send_cmd(CMD_SET_RATE,   16'hFFFF, '1, 32'd0);
      send_cmd(CMD_SET_POLICY, 16'h0000, 31'd0, 32'd100);
      send_cmd(CMD_SET_EXEC,   16'h0000, 31'd9, 32'd0);
      send_cmd(CMD_SET_DL,     16'h0000, 31'd4, 32'd0);
      send_cmd(CMD_SET_POLICY, 16'h0000, 31'd0, 32'd7);
      send_cmd(CMD_SET_DL,     16'h0000, 31'd20, 32'd0);
      send_cmd(CMD_SET_POLICY, 16'h0000, 31'd0, '1);
      send_cmd(CMD_SET_EXEC,   16'h0000, 31'd3, 32'd0);
      send_cmd(CMD_SET_EXEC,   16'hFFFF, 31'd2, 32'd0);
      send_cmd(CMD_SET_POLICY, 16'hFFFF, 31'd1, 32'd50);
      send_cmd(CMD_SET_POLICY, 16'hFFFF, '1, 32'd60);
      send_cmd(CMD_READY,      16'h0000, 31'd0, 32'd0);
      send_cmd(CMD_READY,      16'hFFFF, 31'd0, 32'd0);
      send_cmd(CMD_PICK,       16'h0000, 31'd0, 32'd0);
      send_cmd(CMD_PICK,       16'h0000, 31'd0, 32'd0);
      send_cmd(CMD_PICK,       16'h0000, 31'd0, 32'd0);

      // Sender stops offering and waits for every response before the table-full burst.
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (pending_count == 0);
      @(posedge clock);
      for (int k = 0; k < 66; k++) send_cmd(CMD_ADD, 16'(16'h2000 + k), 31'd0, 32'd0);
      for (int k = 0; k < 66; k++) send_cmd(CMD_REMOVE, 16'(16'h2000 + k), 31'd0, 32'd0);

      // Random part: mostly complete task setups (add, params, policy, ready,
      // then up to two picks), the rest loose commands with random content.
      while (sent_count < 450) begin
         if ($urandom_range(0, 9) < 6) begin
            p = some_pid();
            send_cmd(CMD_ADD, p, some_operand(CMD_ADD), $urandom);
            send_cmd(CMD_SET_EXEC, p, some_operand(CMD_SET_EXEC), $urandom);
            send_cmd(CMD_SET_DL, p, some_operand(CMD_SET_DL), $urandom);
            send_cmd(CMD_SET_RATE, p, some_operand(CMD_SET_RATE), $urandom);
            send_cmd(CMD_SET_POLICY, p, some_operand(CMD_SET_POLICY), $urandom);
            send_cmd(CMD_READY, p, some_operand(CMD_READY), $urandom);
            repeat ($urandom_range(0, 2))
               send_cmd(CMD_PICK, some_pid(), VAL_W'($urandom), $urandom);
            if ($urandom_range(0, 2) == 0)
               send_cmd(CMD_REMOVE, some_pid(), VAL_W'($urandom), $urandom);
         end else begin
            c = CMD_W'($urandom_range(0, 7));
            send_cmd(c, some_pid(), some_operand(c), $urandom);
         end
      end
      req_tvalid <= 1'b0;
      @(posedge clock);

      wait (pending_count == 0);
      repeat (100) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
